### design/pwi_pkg.sv
// Shared constants, codes and controller/datapath interface types of the width interpolator.
package pwi_pkg;

  localparam int TABLE_DEPTH = 64;
  localparam int IDX_W       = $clog2(TABLE_DEPTH);
  localparam int CNT_W       = IDX_W + 1;
  localparam int FRAC_BITS   = 16;
  localparam int DIV_CNT_W   = $clog2(FRAC_BITS + 1);

  // Configuration register indexes.
  localparam logic [2:0] CFG_APP   = 3'd0;
  localparam logic [2:0] CFG_LOWER = 3'd1;
  localparam logic [2:0] CFG_UPPER = 3'd2;
  localparam logic [2:0] CFG_TOL   = 3'd3;
  localparam logic [2:0] CFG_COUNT = 3'd4;

  // Request commands.
  localparam logic CMD_LOAD  = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  // Table read address selection.
  localparam logic [1:0] RD_MID  = 2'd0;
  localparam logic [1:0] RD_LAST = 2'd1;
  localparam logic [1:0] RD_PREV = 2'd2;

  // Result selection.
  localparam logic [1:0] RES_ZERO   = 2'd0;
  localparam logic [1:0] RES_MATCH  = 2'd1;
  localparam logic [1:0] RES_W0     = 2'd2;
  localparam logic [1:0] RES_INTERP = 2'd3;

  typedef struct packed {
    logic       mem_we;
    logic       load_p;
    logic       rd_en;
    logic [1:0] rd_sel;
    logic       srch_upd;
    logic       cap_hi;
    logic       cap_lo;
    logic       div_init;
    logic       div_step;
    logic       mul;
    logic       res_en;
    logic [1:0] res_sel;
  } pwi_cmd_t;

  typedef struct packed {
    logic out_of_range;
    logic srch_done;
    logic lo_is_n;
    logic lo_is_zero;
    logic within_tol;
    logic span_le0;
    logic div_done;
  } pwi_stat_t;

endpackage

### design/profile_width_interpolator_core.sv
// Top level of the profile width interpolator: configuration registers and core wiring.
//
// Requests enter on start with the in_ fields and are taken when busy is low.
// A load request (in_command low) writes one table point in the same cycle and
// leaves the block idle, so loads may follow back to back. A query request
// (in_command high) raises busy and yields one result on out_width, marked by
// out_valid for exactly one cycle; the receiver cannot stall it.
// A query outside the height limits, or on an empty table, gives its result
// from the range check through the result register. Otherwise it passes the
// range check, the binary search steps (up to 7 steps over 64 points), each
// a table read then a compare, the match tests and, when interpolating, the
// bit-serial ratio divider and the multiply and saturation, then the result
// register. The next request is taken at the edge that ends the result cycle.
// The table memory's single read port sets the search pace.
// Configuration writes use cfg_valid/cfg_ready with cfg_index and cfg_data;
// cfg_ready is always high; the user, not the block, must make writes only while idle.
// Synchronous reset (rst_n low) returns the controller to idle and the
// registers to their defaults; table contents are undefined until loaded.
module profile_width_interpolator_core import pwi_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic               in_command,
  input  logic [5:0]         in_entry_index,
  input  logic signed [31:0] in_entry_height,
  input  logic signed [31:0] in_entry_width,
  input  logic signed [31:0] in_height_shift,
  output logic               out_valid,
  output logic signed [31:0] out_width,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [31:0]        cfg_data
);

  logic signed [31:0] app_r, lower_r, upper_r;
  logic [30:0]        tol_r;
  logic [CNT_W-1:0]   count_r;
  pwi_cmd_t           cmd;
  pwi_stat_t          stat;

  assign cfg_ready = 1'b1;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      app_r   <= '0;
      lower_r <= '0;
      upper_r <= '0;
      tol_r   <= 31'd66;
      count_r <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_APP:   app_r   <= cfg_data;
        CFG_LOWER: lower_r <= cfg_data;
        CFG_UPPER: upper_r <= cfg_data;
        CFG_TOL:   tol_r   <= cfg_data[30:0];
        CFG_COUNT: count_r <= cfg_data[CNT_W-1:0];
        default:   ;
      endcase
    end
  end

  pwi_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .in_command (in_command),
    .busy       (busy),
    .stat       (stat),
    .cmd        (cmd)
  );

  pwi_datapath u_datapath (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .stat            (stat),
    .in_entry_index  (in_entry_index),
    .in_entry_height (in_entry_height),
    .in_entry_width  (in_entry_width),
    .in_height_shift (in_height_shift),
    .app_point       (app_r),
    .lower_height    (lower_r),
    .upper_height    (upper_r),
    .tolerance       (tol_r),
    .point_count     (count_r),
    .out_valid       (out_valid),
    .out_width       (out_width)
  );

endmodule

### design/pwi_datapath.sv
// Datapath: profile table memory, search pointers, divider, multiplier and result register.
module pwi_datapath import pwi_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  pwi_cmd_t            cmd,
  output pwi_stat_t           stat,
  input  logic [IDX_W-1:0]    in_entry_index,
  input  logic signed [31:0]  in_entry_height,
  input  logic signed [31:0]  in_entry_width,
  input  logic signed [31:0]  in_height_shift,
  input  logic signed [31:0]  app_point,
  input  logic signed [31:0]  lower_height,
  input  logic signed [31:0]  upper_height,
  input  logic [30:0]         tolerance,
  input  logic [CNT_W-1:0]    point_count,
  output logic                out_valid,
  output logic signed [31:0]  out_width
);

  logic signed [31:0] heights [TABLE_DEPTH];
  logic signed [31:0] widths  [TABLE_DEPTH];

  logic signed [31:0] rd_h_r, rd_w_r;
  logic signed [32:0] p_r;
  logic [CNT_W-1:0]   n_r, lo_r, hi_r;
  logic signed [31:0] h0_r, w0_r, h1_r, w1_r;
  logic [33:0]        rem_r;
  logic [FRAC_BITS:0] ratio_r;
  logic [DIV_CNT_W-1:0] div_cnt_r;
  logic signed [50:0] prod_r;
  logic               out_valid_r;
  logic signed [31:0] out_width_r;

  logic [CNT_W-1:0]   mid, rd_addr;
  logic signed [33:0] diff, span, dz;
  logic [33:0]        adiff, rem2;
  logic signed [32:0] dw;
  logic signed [50:0] prod_adj;
  logic signed [34:0] delta, sum;
  logic signed [31:0] interp;

  // Search midpoint and read address.
  assign mid = lo_r + ((hi_r - lo_r) >> 1);
  always_comb begin
    unique case (cmd.rd_sel)
      RD_MID:  rd_addr = mid;
      RD_LAST: rd_addr = (lo_r == n_r) ? n_r - 1'b1 : lo_r;
      RD_PREV: rd_addr = lo_r - 1'b1;
      default: rd_addr = mid;
    endcase
  end

  // Table memory with registered read.
  always_ff @(posedge clk) begin
    if (cmd.mem_we) begin
      heights[in_entry_index] <= in_entry_height;
      widths[in_entry_index]  <= in_entry_width;
    end
    if (cmd.rd_en) begin
      rd_h_r <= heights[rd_addr[IDX_W-1:0]];
      rd_w_r <= widths[rd_addr[IDX_W-1:0]];
    end
  end

  // Distance and interpolation terms.
  assign diff  = 34'(rd_h_r) - 34'(p_r);
  assign adiff = diff[33] ? 34'(-diff) : 34'(diff);
  assign span  = 34'(h1_r) - 34'(h0_r);
  assign dz    = 34'(p_r) - 34'(h0_r);
  assign rem2  = {rem_r[32:0], 1'b0};
  assign dw    = 33'(w1_r) - 33'(w0_r);

  // Truncate the scaled product toward zero, then saturate the sum.
  assign prod_adj = prod_r + (prod_r[50] ? 51'((1 << FRAC_BITS) - 1) : 51'd0);
  assign delta    = 35'(prod_adj >>> FRAC_BITS);
  assign sum      = 35'(w0_r) + delta;
  always_comb begin
    if (sum > 35'sh07FFFFFFF)       interp = 32'sh7FFFFFFF;
    else if (sum < -35'sh080000000) interp = -32'sh80000000;
    else                            interp = sum[31:0];
  end

  // Status to the controller.
  assign stat.out_of_range = (p_r < 33'(lower_height)) || (p_r > 33'(upper_height)) ||
                             (n_r == '0);
  assign stat.srch_done    = (lo_r >= hi_r);
  assign stat.lo_is_n      = (lo_r == n_r);
  assign stat.lo_is_zero   = (lo_r == '0);
  assign stat.within_tol   = (adiff < 34'(tolerance));
  assign stat.span_le0     = (span <= 0);
  assign stat.div_done     = (div_cnt_r == '0);

  // Query state, search pointers, divider and multiplier.
  always_ff @(posedge clk) begin
    if (cmd.load_p) begin
      p_r  <= 33'(in_height_shift) + 33'(app_point);
      n_r  <= (point_count > CNT_W'(TABLE_DEPTH)) ? CNT_W'(TABLE_DEPTH) : point_count;
      lo_r <= '0;
      hi_r <= (point_count > CNT_W'(TABLE_DEPTH)) ? CNT_W'(TABLE_DEPTH) : point_count;
    end
    if (cmd.srch_upd) begin
      if (34'(rd_h_r) < 34'(p_r)) lo_r <= mid + 1'b1;
      else                        hi_r <= mid;
    end
    if (cmd.cap_hi) begin
      h1_r <= rd_h_r;
      w1_r <= rd_w_r;
    end
    if (cmd.cap_lo) begin
      h0_r <= rd_h_r;
      w0_r <= rd_w_r;
    end
    if (cmd.div_init) begin
      rem_r <= 34'(dz);
      if (dz <= 0) begin
        ratio_r   <= '0;
        div_cnt_r <= '0;
      end else if (dz >= span) begin
        ratio_r   <= (FRAC_BITS+1)'(1 << FRAC_BITS);
        div_cnt_r <= '0;
      end else begin
        ratio_r   <= '0;
        div_cnt_r <= DIV_CNT_W'(FRAC_BITS);
      end
    end else if (cmd.div_step) begin
      div_cnt_r <= div_cnt_r - 1'b1;
      if (rem2 >= 34'(span)) begin
        rem_r   <= rem2 - 34'(span);
        ratio_r <= {ratio_r[FRAC_BITS-1:0], 1'b1};
      end else begin
        rem_r   <= rem2;
        ratio_r <= {ratio_r[FRAC_BITS-1:0], 1'b0};
      end
    end
    if (cmd.mul) begin
      prod_r <= 51'(dw) * 51'($signed({1'b0, ratio_r}));
    end
  end

  // Result register, shown for one cycle.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= cmd.res_en;
    end
    if (cmd.res_en) begin
      unique case (cmd.res_sel)
        RES_ZERO:   out_width_r <= '0;
        RES_MATCH:  out_width_r <= rd_w_r;
        RES_W0:     out_width_r <= w0_r;
        RES_INTERP: out_width_r <= interp;
        default:    out_width_r <= '0;
      endcase
    end
  end

  assign out_valid = out_valid_r;
  assign out_width = out_width_r;

endmodule

### design/pwi_ctrl.sv
// Controller: sequences table loads, the binary search and the interpolation steps.
module pwi_ctrl import pwi_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  input  logic      in_command,
  output logic      busy,
  input  pwi_stat_t stat,
  output pwi_cmd_t  cmd
);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_CHECK = 4'd1;
  localparam logic [3:0] S_SRD   = 4'd2;
  localparam logic [3:0] S_SCMP  = 4'd3;
  localparam logic [3:0] S_TEST1 = 4'd4;
  localparam logic [3:0] S_TEST0 = 4'd5;
  localparam logic [3:0] S_SPAN  = 4'd6;
  localparam logic [3:0] S_DIV   = 4'd7;
  localparam logic [3:0] S_FIN   = 4'd8;

  logic [3:0] state_r, state_nxt;

  assign busy = (state_r != S_IDLE);

  // Next state and datapath commands.
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          if (in_command == CMD_LOAD) begin
            cmd.mem_we = 1'b1;
          end else begin
            cmd.load_p = 1'b1;
            state_nxt  = S_CHECK;
          end
        end
      end
      S_CHECK: begin
        if (stat.out_of_range) begin
          cmd.res_en  = 1'b1;
          cmd.res_sel = RES_ZERO;
          state_nxt   = S_IDLE;
        end else begin
          state_nxt = S_SRD;
        end
      end
      S_SRD: begin
        cmd.rd_en = 1'b1;
        if (stat.srch_done) begin
          cmd.rd_sel = RD_LAST;
          state_nxt  = S_TEST1;
        end else begin
          cmd.rd_sel = RD_MID;
          state_nxt  = S_SCMP;
        end
      end
      S_SCMP: begin
        cmd.srch_upd = 1'b1;
        state_nxt    = S_SRD;
      end
      S_TEST1: begin
        if (stat.within_tol) begin
          cmd.res_en  = 1'b1;
          cmd.res_sel = RES_MATCH;
          state_nxt   = S_IDLE;
        end else if (stat.lo_is_n || stat.lo_is_zero) begin
          cmd.res_en  = 1'b1;
          cmd.res_sel = RES_ZERO;
          state_nxt   = S_IDLE;
        end else begin
          cmd.cap_hi = 1'b1;
          cmd.rd_en  = 1'b1;
          cmd.rd_sel = RD_PREV;
          state_nxt  = S_TEST0;
        end
      end
      S_TEST0: begin
        if (stat.within_tol) begin
          cmd.res_en  = 1'b1;
          cmd.res_sel = RES_MATCH;
          state_nxt   = S_IDLE;
        end else begin
          cmd.cap_lo = 1'b1;
          state_nxt  = S_SPAN;
        end
      end
      S_SPAN: begin
        if (stat.span_le0) begin
          cmd.res_en  = 1'b1;
          cmd.res_sel = RES_W0;
          state_nxt   = S_IDLE;
        end else begin
          cmd.div_init = 1'b1;
          state_nxt    = S_DIV;
        end
      end
      S_DIV: begin
        if (stat.div_done) begin
          cmd.mul   = 1'b1;
          state_nxt = S_FIN;
        end else begin
          cmd.div_step = 1'b1;
        end
      end
      S_FIN: begin
        cmd.res_en  = 1'b1;
        cmd.res_sel = RES_INTERP;
        state_nxt   = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

### verif/tb.sv
// Self-checking testbench for the profile width interpolator core.
module tb import pwi_pkg::*; ();

  localparam int CYCLE_LIMIT = 600000;
  localparam longint S32_MIN = -64'sd2147483648;
  localparam longint S32_MAX = 64'sd2147483647;

  // Mirror of the block: table, registers and the widths still to come.
  class width_scoreboard;
    longint pt_h[TABLE_DEPTH];
    longint pt_w[TABLE_DEPTH];
    longint app_point, lower_lim, upper_lim, tolerance;
    int unsigned point_cnt;
    logic [31:0] pending_widths[$];
    int mismatches, strays, loads, queries, matched;

    function new();
      app_point = 0;
      lower_lim = 0;
      upper_lim = 0;
      tolerance = 66;
      point_cnt = 0;
      mismatches = 0;
      strays = 0;
      loads = 0;
      queries = 0;
      matched = 0;
    endfunction

    function void write_reg(logic [2:0] idx, logic [31:0] d);
      case (idx)
        CFG_APP:   app_point = longint'(signed'(d));
        CFG_LOWER: lower_lim = longint'(signed'(d));
        CFG_UPPER: upper_lim = longint'(signed'(d));
        CFG_TOL:   tolerance = longint'(d[30:0]);
        CFG_COUNT: point_cnt = d[6:0];
        default: ;
      endcase
    endfunction

    function longint gap(longint a, longint b);
      return (a > b) ? a - b : b - a;
    endfunction

    // Width at query height p: limits, lower-bound search, match tests, interpolation.
    function longint width_at(longint p);
      int n, lo, hi, mid;
      longint one, span, dz, ratio, delta, r;
      one = longint'(1) << FRAC_BITS;
      n = (point_cnt > TABLE_DEPTH) ? TABLE_DEPTH : point_cnt;
      if (p < lower_lim || p > upper_lim || n == 0) return 0;
      lo = 0;
      hi = n;
      while (lo < hi) begin
        mid = lo + (hi - lo) / 2;
        if (pt_h[mid] < p) lo = mid + 1;
        else hi = mid;
      end
      if (lo == n) return (gap(pt_h[n-1], p) < tolerance) ? pt_w[n-1] : 0;
      if (gap(pt_h[lo], p) < tolerance) return pt_w[lo];
      if (lo == 0) return 0;
      if (gap(pt_h[lo-1], p) < tolerance) return pt_w[lo-1];
      span = pt_h[lo] - pt_h[lo-1];
      if (span <= 0) return pt_w[lo-1];
      dz = p - pt_h[lo-1];
      ratio = (dz * one) / span;
      if (ratio < 0) ratio = 0;
      if (ratio > one) ratio = one;
      delta = ((pt_w[lo] - pt_w[lo-1]) * ratio) / one;
      r = pt_w[lo-1] + delta;
      if (r > S32_MAX) r = S32_MAX;
      if (r < S32_MIN) r = S32_MIN;
      return r;
    endfunction

    function void note_request(logic cmd, logic [5:0] idx, logic [31:0] eh, logic [31:0] ew,
                               logic [31:0] sh);
      if (cmd == CMD_LOAD) begin
        pt_h[idx] = longint'(signed'(eh));
        pt_w[idx] = longint'(signed'(ew));
        loads++;
      end else begin
        pending_widths.push_back(32'(width_at(longint'(signed'(sh)) + app_point)));
        queries++;
      end
    endfunction

    function void check_width(logic [31:0] got);
      logic [31:0] want;
      if (pending_widths.size() == 0) begin
        strays++;
        $display("unexpected result: width %h", got);
        return;
      end
      want = pending_widths.pop_front();
      if (got !== want) begin
        mismatches++;
        if (mismatches <= 10)
          $display("width mismatch: expected %h, got %h", want, got);
      end else begin
        matched++;
      end
    endfunction
  endclass

  logic clk;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic in_command = CMD_LOAD;
  logic [5:0] in_entry_index = '0;
  logic signed [31:0] in_entry_height = '0;
  logic signed [31:0] in_entry_width = '0;
  logic signed [31:0] in_height_shift = '0;
  logic out_valid;
  logic signed [31:0] out_width;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [2:0] cfg_index = '0;
  logic [31:0] cfg_data = '0;

  width_scoreboard sb = new();
  int idle_pct = 36;
  int cycles = 0;

  profile_width_interpolator_core dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_command(in_command), .in_entry_index(in_entry_index),
    .in_entry_height(in_entry_height), .in_entry_width(in_entry_width),
    .in_height_shift(in_height_shift), .out_valid(out_valid), .out_width(out_width),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Results cannot be held off, so every strobed width is checked at once.
  always @(posedge clk) begin
    if (rst_n && out_valid) sb.check_width(out_width);
  end

  // Watchdog against a hung handshake.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("== FAIL ==");
      $finish;
    end
  end

  // Present one request and hold it until the block takes it.
  task automatic issue(logic cmd, logic [5:0] idx, logic [31:0] eh, logic [31:0] ew,
                       logic [31:0] sh);
    if (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    start <= 1'b1;
    in_command <= cmd;
    in_entry_index <= idx;
    in_entry_height <= eh;
    in_entry_width <= ew;
    in_height_shift <= sh;
    do @(posedge clk); while (busy);
    sb.note_request(cmd, idx, eh, ew, sh);
  endtask

  task automatic load_point(int idx, longint h, longint w);
    issue(CMD_LOAD, 6'(idx), 32'(h), 32'(w), $urandom);
  endtask

  // Query the absolute height target; the shift wraps like the block's port does.
  task automatic ask_height(longint target);
    issue(CMD_QUERY, 6'($urandom), $urandom, $urandom, 32'(target - sb.app_point));
  endtask

  // Let the block drain before touching its registers.
  task automatic drain;
    start <= 1'b0;
    do @(posedge clk); while (sb.pending_widths.size() != 0 || busy);
    repeat (4) @(posedge clk);
  endtask

  // Write requests go back to back; the caller drops cfg_valid after the last one.
  task automatic write_reg(logic [2:0] idx, logic [31:0] d);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= d;
    do @(posedge clk); while (!cfg_ready);
    sb.write_reg(idx, d);
  endtask

  task automatic configure(longint app, longint lo, longint up, longint tol, int cnt);
    drain();
    write_reg(CFG_APP, 32'(app));
    write_reg(CFG_LOWER, 32'(lo));
    write_reg(CFG_UPPER, 32'(up));
    write_reg(CFG_TOL, 32'(tol));
    write_reg(CFG_COUNT, 32'(cnt));
    cfg_valid <= 1'b0;
  endtask

  // Table shapes: ascending, ascending spanning the full range, or unsorted noise.
  task automatic fill_table(int shape);
    longint h;
    h = -longint'($urandom_range(0, 1 << 30));
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      case (shape)
        0: begin
          h = h + $urandom_range(1, 1 << $urandom_range(4, 24));
          load_point(i, h, longint'(signed'($urandom)));
        end
        1: begin
          h = (i == 0) ? S32_MIN : (i == TABLE_DEPTH - 1) ? S32_MAX :
              S32_MIN + longint'(i) * 64'sd67108864 + $urandom_range(0, 1000);
          load_point(i, h, (i % 2 == 0) ? S32_MAX : S32_MIN);
        end
        default: load_point(i, longint'(signed'($urandom)), longint'(signed'($urandom)));
      endcase
    end
  endtask

  // Heights that land on entries, near them, between them, or anywhere.
  function automatic longint pick_height();
    int n, k;
    longint base;
    n = (sb.point_cnt > TABLE_DEPTH) ? TABLE_DEPTH : sb.point_cnt;
    k = (n == 0) ? $urandom_range(TABLE_DEPTH - 1) : $urandom_range(n - 1);
    base = sb.pt_h[k];
    case ($urandom_range(6))
      0: return base;
      1: return base + $urandom_range(0, 140) - 70;
      2: return (k < TABLE_DEPTH - 1) ?
                base + (sb.pt_h[k+1] - base) * $urandom_range(1, 99) / 100 : base;
      3: return longint'(signed'($urandom));
      4: return base - $urandom_range(1, 1 << 18);
      5: return base + $urandom_range(1, 1 << 18);
      default: return (k < TABLE_DEPTH - 1) ? (base + sb.pt_h[k+1]) / 2 : base + 1;
    endcase
  endfunction

  function automatic longint pick_s32();
    case ($urandom_range(4))
      0: return S32_MIN;
      1: return S32_MAX;
      2: return 0;
      default: return longint'(signed'($urandom));
    endcase
  endfunction

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Empty table with reset limits: in range, then above the upper limit.
    ask_height(0);
    ask_height(1);
    configure(0, S32_MIN, S32_MAX, 66, 0);
    ask_height(12345);

    // Full ascending table: exact hit, before first, beyond last, tolerance edges.
    fill_table(0);
    configure(0, S32_MIN, S32_MAX, 66, TABLE_DEPTH);
    ask_height(sb.pt_h[0]);
    ask_height(sb.pt_h[0] - 1000);
    ask_height(sb.pt_h[TABLE_DEPTH-1] + 1000);
    ask_height(sb.pt_h[TABLE_DEPTH-1] + 10);
    ask_height((sb.pt_h[5] + sb.pt_h[6]) / 2);
    ask_height(sb.pt_h[10] + 65);
    ask_height(sb.pt_h[10] + 66);
    ask_height(sb.pt_h[20] - 65);

    // Single point, oversized counts, zero and maximal tolerance.
    configure(0, S32_MIN, S32_MAX, 66, 1);
    ask_height(sb.pt_h[0] - 5);
    ask_height(sb.pt_h[0] + 5000);
    configure(0, S32_MIN, S32_MAX, 0, 100);
    ask_height(sb.pt_h[30]);
    ask_height(sb.pt_h[30] + 1);
    configure(0, S32_MIN, S32_MAX, 64'sd2147483647, 127);
    ask_height(sb.pt_h[40] + 3);

    // Full-range table with extreme widths; shifted application points and limits.
    fill_table(1);
    configure(S32_MAX, S32_MIN, S32_MAX, 66, TABLE_DEPTH);
    ask_height(S32_MAX);
    ask_height(sb.pt_h[7] + 12345678);
    configure(S32_MIN, S32_MIN, S32_MAX, 66, TABLE_DEPTH);
    ask_height(S32_MIN);
    ask_height(sb.pt_h[50] - 999);
    configure(0, 1000, -1000, 66, TABLE_DEPTH);
    ask_height(0);

    // Random phases: mostly well-formed tables and targeted heights, some noise.
    for (int ph = 0; ph < 8; ph++) begin
      idle_pct = (ph == 4) ? 0 : 36;
      if (ph % 4 == 0) fill_table(ph == 4 ? 2 : 0);
      else for (int j = 0; j < 6; j++)
        load_point($urandom_range(TABLE_DEPTH - 1), pick_s32(), pick_s32());
      if ($urandom_range(3) == 0)
        configure(pick_s32(), pick_s32(), pick_s32(), pick_s32() & 64'h7fffffff,
                  $urandom_range(127));
      else
        configure($urandom_range(0, 1) ? 0 : longint'(signed'($urandom)) / 4,
                  S32_MIN, S32_MAX, $urandom_range(0, 3) == 0 ? $urandom : 66,
                  $urandom_range(0, 3) == 0 ? $urandom_range(127) : TABLE_DEPTH);
      for (int j = 0; j < 16; j++) begin
        if ($urandom_range(9) == 0)
          load_point($urandom_range(TABLE_DEPTH - 1), pick_s32(), pick_s32());
        ask_height(pick_height());
      end
    end

    drain();
    repeat (60) @(posedge clk);
    $display("covered %0d queries and %0d table loads; %0d widths matched",
             sb.queries, sb.loads, sb.matched);
    $display("%0d mismatches, %0d unexpected results, %0d results missing",
             sb.mismatches, sb.strays, sb.pending_widths.size());
    if (sb.mismatches == 0 && sb.strays == 0 && sb.pending_widths.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end
endmodule

### profile_width_interpolator_core.f
design/pwi_pkg.sv
design/pwi_datapath.sv
design/pwi_ctrl.sv
design/profile_width_interpolator_core.sv
verif/tb.sv
